[rtl/csa_pkg.sv]
package csa_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_REM = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] left_operand;
        logic signed [31:0] right_operand;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_rsp;

endpackage

[rtl/csa_div_step.sv]
module csa_div_step
    import csa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    input  logic [DATA_WIDTH-1:0] i_div,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo
);

    logic [DATA_WIDTH:0] w_trial;
    logic [DATA_WIDTH:0] w_diff;
    logic                w_ge;

    always_comb begin
        w_trial = {i_rem, i_quo[DATA_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        o_rem   = w_ge ? w_diff[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
        o_quo   = {i_quo[DATA_WIDTH-2:0], w_ge};
    end

endmodule

[rtl/checked_signed_alu_core.sv]
// Throughput: one request per cycle unless stalled; one quotient bit per divider stage.
// The product is built from four half-width partial products over three stages.
// A stalled result holds the whole pipeline until it is taken.
// Reset is synchronous, active low, and clears only the valid bits.
module checked_signed_alu_core
    import csa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int H  = W / 2;
    localparam int HI = W - H;
    localparam int P  = 2 * W;

    logic w_en;

    logic r_in_v;
    t_req r_in;

    logic                    r_v     [0:W];
    logic [2:0]              r_op    [0:W];
    logic [W-1:0]            r_ma;
    logic [W-1:0]            r_mb    [0:W-1];
    logic [W-1:0]            r_quo   [0:W];
    logic [W-1:0]            r_rem   [0:W];
    logic                    r_qneg  [0:W];
    logic                    r_rneg  [0:W];
    logic                    r_bzero [0:W];
    logic                    r_amin  [0:W];
    logic                    r_bm1   [0:W];
    logic [W-1:0]            r_pval  [0:W];
    logic [1:0]              r_pst   [0:W];
    logic [P-1:0]            r_p0    [1:2];
    logic [P-1:0]            r_p1    [1:1];
    logic [P-1:0]            r_p2    [1:1];
    logic [P-1:0]            r_p3    [1:2];
    logic [P-1:0]            r_pm    [2:2];
    logic [P-1:0]            r_prod  [3:W];

    logic r_out_v;
    t_rsp r_out;

    assign o_stall = r_out_v && i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_valid;
        end
        if (w_en) begin
            r_in <= i_req;
        end
    end

    logic signed [W-1:0] f_sa;
    logic signed [W-1:0] f_sb;
    logic [W:0]          f_sum;
    logic [W:0]          f_dif;
    logic [W-1:0]        f_val;
    logic [1:0]          f_st;

    always_comb begin
        f_sa  = W'(r_in.left_operand);
        f_sb  = W'(r_in.right_operand);
        f_sum = {f_sa[W-1], f_sa} + {f_sb[W-1], f_sb};
        f_dif = {f_sa[W-1], f_sa} - {f_sb[W-1], f_sb};
        f_val = '0;
        f_st  = ST_OK;
        case (r_in.action)
            ACT_ADD: begin
                if (f_sum[W] != f_sum[W-1]) begin
                    f_st = f_sum[W] ? ST_UNDER : ST_OVER;
                end else begin
                    f_val = f_sum[W-1:0];
                end
            end
            ACT_SUB: begin
                if (f_dif[W] != f_dif[W-1]) begin
                    f_st = f_dif[W] ? ST_UNDER : ST_OVER;
                end else begin
                    f_val = f_dif[W-1:0];
                end
            end
            default: begin
                f_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= r_in_v;
        end
        if (w_en) begin
            r_op[0]    <= r_in.action;
            r_ma       <= f_sa[W-1] ? W'(-f_sa) : W'(f_sa);
            r_mb[0]    <= f_sb[W-1] ? W'(-f_sb) : W'(f_sb);
            r_quo[0]   <= f_sa[W-1] ? W'(-f_sa) : W'(f_sa);
            r_rem[0]   <= '0;
            r_qneg[0]  <= f_sa[W-1] ^ f_sb[W-1];
            r_rneg[0]  <= f_sa[W-1];
            r_bzero[0] <= (f_sb == '0);
            r_amin[0]  <= (f_sa == {1'b1, {(W-1){1'b0}}});
            r_bm1[0]   <= (&f_sb);
            r_pval[0]  <= f_val;
            r_pst[0]   <= f_st;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_stage
        logic [W-1:0] w_rem;
        logic [W-1:0] w_quo;

        csa_div_step #(
            .DATA_WIDTH(W)
        ) u_step (
            .i_rem(r_rem[k-1]),
            .i_quo(r_quo[k-1]),
            .i_div(r_mb[k-1]),
            .o_rem(w_rem),
            .o_quo(w_quo)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_en) begin
                r_op[k]    <= r_op[k-1];
                r_quo[k]   <= w_quo;
                r_rem[k]   <= w_rem;
                r_qneg[k]  <= r_qneg[k-1];
                r_rneg[k]  <= r_rneg[k-1];
                r_bzero[k] <= r_bzero[k-1];
                r_amin[k]  <= r_amin[k-1];
                r_bm1[k]   <= r_bm1[k-1];
                r_pval[k]  <= r_pval[k-1];
                r_pst[k]   <= r_pst[k-1];
            end
        end

        if (k < W) begin : g_mbcopy
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_mb[k] <= r_mb[k-1];
                end
            end
        end

        if (k == 1) begin : g_part
            logic [2*H-1:0]  w_m0;
            logic [H+HI-1:0] w_m1;
            logic [H+HI-1:0] w_m2;
            logic [2*HI-1:0] w_m3;
            assign w_m0 = r_ma[H-1:0] * r_mb[0][H-1:0];
            assign w_m1 = r_ma[H-1:0] * r_mb[0][W-1:H];
            assign w_m2 = r_ma[W-1:H] * r_mb[0][H-1:0];
            assign w_m3 = r_ma[W-1:H] * r_mb[0][W-1:H];
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_p0[k] <= P'(w_m0);
                    r_p1[k] <= P'(w_m1);
                    r_p2[k] <= P'(w_m2);
                    r_p3[k] <= P'(w_m3);
                end
            end
        end else if (k == 2) begin : g_pcopy
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_p0[k] <= r_p0[k-1];
                    r_p3[k] <= r_p3[k-1];
                end
            end
        end

        if (k == 2) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pm[k] <= r_p1[k-1] + r_p2[k-1];
                end
            end
        end

        if (k == 3) begin : g_prod
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_prod[k] <= r_p0[k-1] + (r_pm[k-1] << H) + (r_p3[k-1] << (2 * H));
                end
            end
        end else if (k > 3) begin : g_prodcopy
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_prod[k] <= r_prod[k-1];
                end
            end
        end
    end

    logic [P-1:0]        b_limit;
    logic                b_neg;
    logic signed [W-1:0] b_val;
    logic [1:0]          b_st;

    always_comb begin
        b_neg   = r_qneg[W] && (r_prod[W] != '0);
        b_limit = b_neg ? P'({1'b1, {(W-1){1'b0}}}) : P'({1'b0, {(W-1){1'b1}}});
        b_val   = '0;
        b_st    = ST_OK;
        case (r_op[W])
            ACT_ADD, ACT_SUB: begin
                b_val = r_pval[W];
                b_st  = r_pst[W];
            end
            ACT_MUL: begin
                if (r_prod[W] > b_limit) begin
                    b_st = b_neg ? ST_UNDER : ST_OVER;
                end else begin
                    b_val = b_neg ? -r_prod[W][W-1:0] : r_prod[W][W-1:0];
                end
            end
            ACT_DIV: begin
                if (r_bzero[W]) begin
                    b_st = ST_DIVZ;
                end else if (r_amin[W] && r_bm1[W]) begin
                    b_st = ST_OVER;
                end else begin
                    b_val = r_qneg[W] ? -r_quo[W] : r_quo[W];
                end
            end
            ACT_REM: begin
                if (r_bzero[W]) begin
                    b_st = ST_DIVZ;
                end else begin
                    b_val = r_rneg[W] ? -r_rem[W] : r_rem[W];
                end
            end
            default: begin
                b_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_v[W];
        end
        if (w_en) begin
            r_out.value  <= 32'(b_val);
            r_out.status <= b_st;
        end
    end

endmodule

[rtl/csa_checker.sv]
module csa_checker
    import csa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("Stalled result changed.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Request stalled without a stalled result.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status != ST_OK) |-> (o_rsp.value == '0))
        else $error("Error result carries a nonzero value.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

endmodule

bind checked_signed_alu_core csa_checker u_csa_checker (.*);

[verif/checked_signed_alu_core_tb.sv]
`timescale 1ns / 100ps

module checked_signed_alu_core_tb;
    import csa_pkg::*;

    localparam int LATENCY     = DATA_WIDTH_DEF + 2;
    localparam int RANDOM_REQS = 550;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] left_operand;
        logic [31:0] right_operand;
        logic        has_value;
        t_rsp        value_and_status;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    t_rsp pending_results[$];
    int   mismatch_count;
    int   cycle_count;
    bit   reset_done;

    checked_signed_alu_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_rsp alu_result(t_req req);
        t_rsp r;
        longint a;
        longint b;
        longint wide;
        a = longint'($signed(req.left_operand));
        b = longint'($signed(req.right_operand));
        r.value = '0;
        r.status = ST_OK;
        case (req.action)
            ACT_ADD, ACT_SUB, ACT_MUL: begin
                if (req.action == ACT_ADD) begin
                    wide = a + b;
                end else if (req.action == ACT_SUB) begin
                    wide = a - b;
                end else begin
                    wide = a * b;
                end
                if (wide > 64'sd2147483647) begin
                    r.status = ST_OVER;
                end else if (wide < -64'sd2147483648) begin
                    r.status = ST_UNDER;
                end else begin
                    r.value = wide[31:0];
                end
            end
            ACT_DIV: begin
                if (b == 0) begin
                    r.status = ST_DIVZ;
                end else if (a == -64'sd2147483648 && b == -1) begin
                    r.status = ST_OVER;
                end else begin
                    wide = a / b;
                    r.value = wide[31:0];
                end
            end
            ACT_REM: begin
                if (b == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    wide = a % b;
                    r.value = wide[31:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = '0;
            4: v = 32'($signed($urandom_range(0, 40)) - 20);
            5: v = {{16{v[31]}}, v[15:0]};
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_request(t_req req);
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(alu_result(req));
        if ($urandom_range(0, 3) == 0) begin
            idle_gap();
        end
    endtask

    task automatic check_result(t_rsp expected, t_rsp actual);
        if (expected !== actual) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                         expected.value, expected.status, actual.value, actual.status);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp expected;
        if (reset_done && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: value %0d status %0d",
                             o_rsp.value, o_rsp.status);
                end
            end else begin
                expected = pending_results.pop_front();
                check_result(expected, o_rsp);
            end
        end
    end

    always @(posedge i_clk) begin
        int n;
        if (!reset_done || $urandom_range(0, 9) < 6) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(5, 30);
            i_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
            i_stall <= 1'b0;
        end else begin
            i_stall <= $urandom_range(0, 1);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("checked_signed_alu_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_directed_row rows[$];
        t_req req;
        rows = '{
            '{ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDER}},
            '{ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK}},
            '{ACT_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h0, ST_UNDER}},
            '{ACT_SUB, 32'h0000_0000, 32'h8000_0000, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_SUB, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK}},
            '{ACT_MUL, 32'h0001_0000, 32'h0001_0000, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_MUL, 32'h0001_0000, 32'hFFFF_0000, 1'b1, '{32'h0, ST_UNDER}},
            '{ACT_MUL, 32'h0000_8000, 32'hFFFF_0000, 1'b1, '{32'h8000_0000, ST_OK}},
            '{ACT_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_MUL, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0, ST_OK}},
            '{ACT_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_MUL, 32'hFFFF_D8F1, 32'h0003_4A1B, 1'b0, '{32'h0, ST_OK}},
            '{ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OVER}},
            '{ACT_DIV, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, ST_DIVZ}},
            '{ACT_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 1'b1, '{32'hFFFF_FFFD, ST_OK}},
            '{ACT_DIV, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h1, ST_OK}},
            '{ACT_REM, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}},
            '{ACT_REM, 32'h0000_0005, 32'h0000_0000, 1'b1, '{32'h0, ST_DIVZ}},
            '{ACT_REM, 32'hFFFF_FFF9, 32'h0000_0002, 1'b1, '{32'hFFFF_FFFF, ST_OK}},
            '{ACT_REM, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK}},
            '{3'd5, 32'h1234_5678, 32'h0000_0001, 1'b1, '{32'h0, ST_OK}},
            '{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}},
            '{3'd7, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0, ST_OK}}
        };
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        mismatch_count = 0;
        cycle_count = 0;
        reset_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            req.action = rows[i].action;
            req.left_operand = rows[i].left_operand;
            req.right_operand = rows[i].right_operand;
            if (rows[i].has_value && alu_result(req) !== rows[i].value_and_status) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("predictor disagrees with table row %0d", i);
                end
            end
            send_request(req);
        end
        for (int n = 0; n < RANDOM_REQS; n++) begin
            req.action = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
            req.left_operand = random_operand();
            req.right_operand = random_operand();
            send_request(req);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("checked_signed_alu_core_tb: done, clean");
        end else begin
            $display("checked_signed_alu_core_tb: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/csa_pkg.sv
rtl/csa_div_step.sv
rtl/checked_signed_alu_core.sv
rtl/csa_checker.sv
verif/checked_signed_alu_core_tb.sv
